FILE: rtl/range_sensor_frame_parser_unit_defines.svh
// Assertion macros shared by the frame parser RTL.
`ifndef RANGE_SENSOR_FRAME_PARSER_UNIT_DEFINES_SVH
`define RANGE_SENSOR_FRAME_PARSER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Condition must hold whenever the trigger holds in the same cycle.
`define RSFP_ASSERT_IMPL(label, clk, rst_n, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
		else $error("rsfp assertion failed");
// Condition must hold in the cycle after the trigger.
`define RSFP_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
		else $error("rsfp assertion failed");
`else
`define RSFP_ASSERT_IMPL(label, clk, rst_n, trig, cond)
`define RSFP_ASSERT_NEXT(label, clk, rst_n, trig, cond)
`endif

`endif

FILE: rtl/rsfp_pkg.sv
package rsfp_pkg;

	localparam int ByteW = 8;
	localparam int PosW  = 5;
	localparam int RawW  = 16;
	localparam int DistW = 20;

	localparam logic [ByteW-1:0] HDR0      = 8'hAE;
	localparam logic [ByteW-1:0] HDR1      = 8'hA7;
	localparam logic [ByteW-1:0] LEN_SHORT = 8'h04;
	localparam logic [ByteW-1:0] LEN_FULL  = 8'h17;
	localparam logic [ByteW-1:0] END0      = 8'hBC;
	localparam logic [ByteW-1:0] END1      = 8'hBE;

	// Byte positions within the frame.
	localparam logic [PosW-1:0] POS_HDR0     = 5'd0;
	localparam logic [PosW-1:0] POS_HDR1     = 5'd1;
	localparam logic [PosW-1:0] POS_LEN      = 5'd2;
	localparam logic [PosW-1:0] POS_BODY     = 5'd3;
	localparam logic [PosW-1:0] POS_DIST_HI  = 5'd7;
	localparam logic [PosW-1:0] POS_DIST_LO  = 5'd8;
	localparam logic [PosW-1:0] POS_LAST_SUM = 5'd23;
	localparam logic [PosW-1:0] POS_CHECK    = 5'd24;
	localparam logic [PosW-1:0] POS_END0     = 5'd25;
	localparam logic [PosW-1:0] POS_END1     = 5'd26;

	localparam logic KIND_DIST  = 1'b0;
	localparam logic KIND_SHORT = 1'b1;

	typedef struct packed {
		logic             kind;
		logic [DistW-1:0] distance;
	} report_t;

	typedef struct packed {
		logic    valid;
		report_t rpt;
	} result_t;

	// raw * 10 as (raw << 3) + (raw << 1); the result always fits in 20 bits.
	function automatic logic [DistW-1:0] scale10(input logic [RawW-1:0] raw);
		logic [DistW-1:0] ext;
		ext = {{(DistW-RawW){1'b0}}, raw};
		return (ext << 3) + (ext << 1);
	endfunction

endpackage

FILE: rtl/rsfp_byte_if.sv
interface rsfp_byte_if;
	logic                       valid;
	logic                       ready;
	logic [rsfp_pkg::ByteW-1:0] rx_byte;

	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

FILE: rtl/rsfp_report_if.sv
interface rsfp_report_if;
	logic                       valid;
	logic                       ready;
	logic                       report_kind;
	logic [rsfp_pkg::DistW-1:0] distance_mm;

	modport source(output valid, output report_kind, output distance_mm, input ready);
	modport sink(input valid, input report_kind, input distance_mm, output ready);
endinterface

FILE: rtl/rsfp_frame_fsm.sv
module rsfp_frame_fsm (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [rsfp_pkg::ByteW-1:0] byte_in,
	output rsfp_pkg::result_t          res,
	output logic [rsfp_pkg::PosW-1:0]  pos
);

	logic [rsfp_pkg::PosW-1:0]  pos_q, pos_d;
	logic [rsfp_pkg::ByteW-1:0] sum_q, sum_d;
	logic [rsfp_pkg::ByteW-1:0] dist_hi_q, dist_lo_q, check_q;

	always_comb begin
		pos_d = pos_q;
		sum_d = sum_q;
		res   = '0;
		if (step) begin
			priority if (pos_q == rsfp_pkg::POS_HDR0) begin
				pos_d = (byte_in == rsfp_pkg::HDR0) ? rsfp_pkg::POS_HDR1 : rsfp_pkg::POS_HDR0;
			end else if (pos_q == rsfp_pkg::POS_HDR1) begin
				pos_d = (byte_in == rsfp_pkg::HDR1) ? rsfp_pkg::POS_LEN : rsfp_pkg::POS_HDR0;
			end else if (pos_q == rsfp_pkg::POS_LEN) begin
				pos_d = rsfp_pkg::POS_HDR0;
				if (byte_in == rsfp_pkg::LEN_SHORT) begin
					res.valid    = 1'b1;
					res.rpt.kind = rsfp_pkg::KIND_SHORT;
				end else if (byte_in == rsfp_pkg::LEN_FULL) begin
					// The length byte opens the running checksum.
					sum_d = byte_in;
					pos_d = rsfp_pkg::POS_BODY;
				end
			end else if (pos_q <= rsfp_pkg::POS_LAST_SUM) begin
				sum_d = sum_q + byte_in;
				pos_d = pos_q + 5'd1;
			end else if (pos_q == rsfp_pkg::POS_CHECK) begin
				pos_d = rsfp_pkg::POS_END0;
			end else if (pos_q == rsfp_pkg::POS_END0) begin
				pos_d = (byte_in == rsfp_pkg::END0) ? rsfp_pkg::POS_END1 : rsfp_pkg::POS_HDR0;
			end else if (pos_q == rsfp_pkg::POS_END1) begin
				pos_d = rsfp_pkg::POS_HDR0;
				if (byte_in == rsfp_pkg::END1 && sum_q == check_q) begin
					res.valid        = 1'b1;
					res.rpt.kind     = rsfp_pkg::KIND_DIST;
					res.rpt.distance = rsfp_pkg::scale10({dist_hi_q, dist_lo_q});
				end
			end else begin
				pos_d = rsfp_pkg::POS_HDR0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= rsfp_pkg::POS_HDR0;
			sum_q <= '0;
		end else begin
			pos_q <= pos_d;
			sum_q <= sum_d;
		end
	end

	// Captured frame bytes; always written in a frame before they are read.
	always_ff @(posedge clk) begin
		if (step && pos_q == rsfp_pkg::POS_DIST_HI) begin
			dist_hi_q <= byte_in;
		end
		if (step && pos_q == rsfp_pkg::POS_DIST_LO) begin
			dist_lo_q <= byte_in;
		end
		if (step && pos_q == rsfp_pkg::POS_CHECK) begin
			check_q <= byte_in;
		end
	end

	assign pos = pos_q;

endmodule

FILE: rtl/rsfp_out_stage.sv
module rsfp_out_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rsfp_pkg::result_t    res,
	output logic                 slot_free,
	rsfp_report_if.source        report
);

	logic              valid_q;
	rsfp_pkg::report_t rpt_q;

	assign slot_free = !valid_q || report.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (slot_free) begin
			valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && res.valid) begin
			rpt_q <= res.rpt;
		end
	end

	assign report.valid       = valid_q;
	assign report.report_kind = rpt_q.kind;
	assign report.distance_mm = rpt_q.distance;

endmodule

FILE: rtl/range_sensor_frame_parser_unit.sv
// A result beat is offered from the output register after its completing byte beat leaves the input register.
// Throughput: one byte beat per cycle; the input register drains whenever the
// output register is empty or being taken, so only output backpressure stalls input.
// Reset clears the frame position, running checksum and both valid flags at once;
// the captured distance and checksum bytes are not reset.
`include "range_sensor_frame_parser_unit_defines.svh"

module range_sensor_frame_parser_unit (
	input  logic          clk,
	input  logic          arst_n,
	rsfp_byte_if.sink     rx,
	rsfp_report_if.source rpt
);

	logic                       valid_s1;
	logic [rsfp_pkg::ByteW-1:0] byte_s1;
	logic                       slot_free;
	logic                       step;
	rsfp_pkg::result_t          res;
	logic [rsfp_pkg::PosW-1:0]  pos;

	assign step     = valid_s1 && slot_free;
	assign rx.ready = !valid_s1 || slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	rsfp_frame_fsm u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_in (byte_s1),
		.res     (res),
		.pos     (pos)
	);

	rsfp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.slot_free (slot_free),
		.report    (rpt)
	);

	// The frame position never leaves the 27-byte frame.
	`RSFP_ASSERT_IMPL(a_pos_range, clk, arst_n, 1'b1, pos <= rsfp_pkg::POS_END1)
	// A distance report is only produced by the closing end byte.
	`RSFP_ASSERT_IMPL(a_dist_on_end, clk, arst_n,
		res.valid && res.rpt.kind == rsfp_pkg::KIND_DIST,
		byte_s1 == rsfp_pkg::END1 && pos == rsfp_pkg::POS_END1)
	// An out-of-range report carries zero distance.
	`RSFP_ASSERT_IMPL(a_short_zero, clk, arst_n,
		rpt.valid && rpt.report_kind == rsfp_pkg::KIND_SHORT, rpt.distance_mm == '0)
	// A result loaded into the output register is offered in the next cycle.
	`RSFP_ASSERT_NEXT(a_result_shown, clk, arst_n, res.valid, rpt.valid)

endmodule
